/* rtl/swm_pkg.sv */
// shared types and constants for the sliding window maximum block
// no dependencies; imported by swm_ctrl, swm_dp and sliding_window_maximum
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = IDX_W + 1;
    localparam int POS_W       = IDX_W + 1;
    localparam int LEN_W       = 7;
    localparam int WORD_W      = SAMPLE_BITS + POS_W;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT_REQ,
        S_FRONT_CHK,
        S_BACK_REQ,
        S_BACK_CHK,
        S_APPEND,
        S_OUT_REQ,
        S_OUT_RD
    } t_state;

    // which deque end the memory read port looks at
    typedef enum logic {
        RD_FRONT,
        RD_BACK
    } t_rd_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    front_pop;
        logic    back_pop;
        logic    append;
        logic    out_load;
        t_rd_sel rd_sel;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic front_old;
        logic back_less;
        logic full_after;
        logic out_free;
    } t_status;

endpackage

/* rtl/swm_ctrl.sv */
// sequencer for the sliding window maximum block
// depends on swm_pkg; drives commands into swm_dp
module swm_ctrl
    import swm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FRONT_REQ;
            end
            S_FRONT_REQ: begin
                n_state = i_status.cnt_zero ? S_BACK_REQ : S_FRONT_CHK;
            end
            S_FRONT_CHK: begin
                n_state = i_status.front_old ? S_FRONT_REQ : S_BACK_REQ;
            end
            S_BACK_REQ: begin
                n_state = i_status.cnt_zero ? S_APPEND : S_BACK_CHK;
            end
            S_BACK_CHK: begin
                n_state = i_status.back_less ? S_BACK_REQ : S_APPEND;
            end
            S_APPEND: begin
                n_state = i_status.full_after ? S_OUT_REQ : S_IDLE;
            end
            S_OUT_REQ: begin
                n_state = S_OUT_RD;
            end
            S_OUT_RD: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_sel = RD_FRONT;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_FRONT_REQ: begin
                o_cmd.rd_sel = RD_FRONT;
            end
            S_FRONT_CHK: begin
                o_cmd.front_pop = i_status.front_old;
            end
            S_BACK_REQ: begin
                o_cmd.rd_sel = RD_BACK;
            end
            S_BACK_CHK: begin
                o_cmd.back_pop = i_status.back_less;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
            end
            S_OUT_REQ: begin
                o_cmd.rd_sel = RD_FRONT;
            end
            S_OUT_RD: begin
                o_cmd.rd_sel   = RD_FRONT;
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/swm_dp.sv */
// datapath: deque memory, ring pointers, window registers and output register
// depends on swm_pkg; controlled by swm_ctrl
module swm_dp
    import swm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    input  logic                          i_cfg_we,
    input  logic [LEN_W-1:0]              i_cfg_wdata,
    input  logic                          i_out_stall,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_window_max
);

    logic [WORD_W-1:0] r_mem [WINDOW_MAX];
    logic [WORD_W-1:0] r_rd_data;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [IDX_W-1:0]              r_head;
    logic [CNT_W-1:0]              r_count;
    logic [POS_W-1:0]              r_pos;
    logic [CNT_W-1:0]              r_fill;
    logic [LEN_W-1:0]              r_len;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic [IDX_W-1:0]              rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [POS_W-1:0]              rd_pos;
    logic [POS_W-1:0]              age;
    logic [CNT_W-1:0]              fill_inc;
    logic                          deque_full;
    logic [IDX_W-1:0]              head_adj;
    logic [CNT_W-1:0]              count_adj;
    logic [IDX_W-1:0]              wr_addr;
    logic [LEN_W-1:0]              cfg_len;

    // read address: front entry or back entry of the ring
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FRONT: rd_addr = r_head;
            RD_BACK:  rd_addr = r_head + r_count[IDX_W-1:0] - IDX_W'(1);
            default:  rd_addr = r_head;
        endcase
    end

    // append slot; a full deque gives up its oldest entry
    always_comb begin
        deque_full = (r_count == CNT_W'(WINDOW_MAX));
        head_adj   = deque_full ? r_head + IDX_W'(1) : r_head;
        count_adj  = deque_full ? r_count - CNT_W'(1) : r_count;
        wr_addr    = head_adj + count_adj[IDX_W-1:0];
    end

    // deque memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[wr_addr] <= {r_sample, r_pos};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign rd_val = r_rd_data[WORD_W-1:POS_W];
    assign rd_pos = r_rd_data[POS_W-1:0];

    // compares for the controller
    always_comb begin
        age      = r_pos - rd_pos;
        fill_inc = (r_fill < CNT_W'(WINDOW_MAX)) ? r_fill + CNT_W'(1) : r_fill;
        o_status.cnt_zero   = (r_count == '0);
        o_status.front_old  = (age >= r_len);
        o_status.back_less  = (rd_val < r_sample);
        o_status.full_after = (fill_inc >= r_len);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // effective window length: zero acts as one, large values saturate
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_len = LEN_W'(1);
        end else if (i_cfg_wdata > LEN_W'(WINDOW_MAX)) begin
            cfg_len = LEN_W'(WINDOW_MAX);
        end else begin
            cfg_len = i_cfg_wdata;
        end
    end

    // window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            r_len <= cfg_len;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
    end

    // ring pointers and stream counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
        end else begin
            priority if (i_cmd.load && i_restart) begin
                r_head  <= '0;
                r_count <= '0;
                r_pos   <= '0;
                r_fill  <= '0;
            end else if (i_cmd.front_pop) begin
                r_head  <= r_head + IDX_W'(1);
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.back_pop) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.append) begin
                r_head  <= head_adj;
                r_count <= count_adj + CNT_W'(1);
                r_pos   <= r_pos + POS_W'(1);
                r_fill  <= fill_inc;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= rd_val;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

endmodule

/* rtl/sliding_window_maximum.sv */
// Running maximum over the last window_len samples, kept in a monotonic deque
// in a 64-entry memory with registered read. After an item is accepted, entries
// that left the window are dropped at the front, smaller entries are popped at the
// back and the item is appended; once the window is full, the front is read into
// the output register, waiting out any output stall. New items stall until then.
// Reset (synchronous, active low) empties the deque and sets the window length to 1.
module sliding_window_maximum
    import swm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_window_max,
    input  logic                          i_cfg_we,
    input  logic [LEN_W-1:0]              i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // deque storage and arithmetic
    swm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_window_max (o_window_max)
    );

endmodule

/* tb/sv/swm_window_max_checker.sv */
// checker for sliding_window_maximum: watches both channels and the config port,
// predicts each window maximum and compares it with the block's results
// depends on swm_pkg
module swm_window_max_checker
    import swm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_window_max,
    input  logic                          i_cfg_we,
    input  logic [LEN_W-1:0]              i_cfg_wdata,
    output int                            o_pending,
    output int                            o_errors
);

    localparam int EXP_DEPTH = 64;

    // predictor state: ring of candidate samples with their stream positions
    logic signed [SAMPLE_BITS-1:0] cand_val [WINDOW_MAX];
    logic [POS_W-1:0]              cand_pos [WINDOW_MAX];
    int unsigned                   cand_head;
    int unsigned                   cand_cnt;
    logic [POS_W-1:0]              stream_pos;
    int unsigned                   seen_cnt;
    logic [LEN_W-1:0]              win_len;

    // expected results in arrival order
    logic signed [SAMPLE_BITS-1:0] exp_fifo [EXP_DEPTH];
    int unsigned                   exp_wr;
    int unsigned                   exp_rd;
    logic signed [SAMPLE_BITS-1:0] want;
    int                            err_cnt;

    // advance the predictor by one item, queue the maximum if the window is full
    function automatic void predict_window_max(input logic signed [SAMPLE_BITS-1:0] s,
                                               input logic rs);
        int unsigned      span;
        int unsigned      slot;
        logic [POS_W-1:0] age;
        span = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
        if (rs) begin
            cand_cnt   = 0;
            cand_head  = 0;
            seen_cnt   = 0;
            stream_pos = '0;
        end
        // expire front entries that left the window
        while (cand_cnt > 0) begin
            age = stream_pos - cand_pos[cand_head];
            if (age < span) break;
            cand_head = (cand_head + 1) % WINDOW_MAX;
            cand_cnt--;
        end
        // drop strictly smaller entries from the back, ties stay
        while (cand_cnt > 0) begin
            slot = (cand_head + cand_cnt - 1) % WINDOW_MAX;
            if (cand_val[slot] >= s) break;
            cand_cnt--;
        end
        if (cand_cnt >= WINDOW_MAX) begin
            cand_head = (cand_head + 1) % WINDOW_MAX;
            cand_cnt--;
        end
        slot           = (cand_head + cand_cnt) % WINDOW_MAX;
        cand_val[slot] = s;
        cand_pos[slot] = stream_pos;
        cand_cnt++;
        stream_pos = stream_pos + 1'b1;
        if (seen_cnt < WINDOW_MAX) seen_cnt++;
        if (seen_cnt >= span) begin
            exp_fifo[exp_wr % EXP_DEPTH] = cand_val[cand_head];
            exp_wr++;
        end
    endfunction

    // sample channels at each edge: results first, then new items, then config
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_head  = 0;
            cand_cnt   = 0;
            stream_pos = '0;
            seen_cnt   = 0;
            win_len    = 1;
            exp_wr     = 0;
            exp_rd     = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (exp_wr == exp_rd) begin
                    $error("window_max: unexpected result, actual %0d", i_window_max);
                    err_cnt++;
                end else begin
                    want = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_window_max !== want) begin
                        $error("window_max mismatch: expected %0d, actual %0d",
                               want, i_window_max);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_window_max(i_sample, i_restart);
            if (i_cfg_we) win_len = i_cfg_wdata;
        end
        o_pending <= int'(exp_wr - exp_rd);
        o_errors  <= err_cnt;
    end

endmodule

/* tb/sv/sliding_window_maximum_tb.sv */
// testbench top for sliding_window_maximum: clock, reset, stimulus and verdict
// depends on swm_pkg, sliding_window_maximum and swm_window_max_checker
module sliding_window_maximum_tb;
    import swm_pkg::*;

    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1500;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                          i_restart   = 1'b0;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]              i_cfg_wdata = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [SAMPLE_BITS-1:0] o_window_max;

    int pending;
    int errors;

    // idle rates and long hold-off requests for the receiver
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_req_seq  = 0;
    int hold_seen_seq = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    int win_choices [14] = '{1, 64, 127, 0, 2, 65, 3, 8, 16, 33, 100, 64, 1, 5};

    sliding_window_maximum uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_max (o_window_max),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    swm_window_max_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_window_max (o_window_max),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #8000000;
        $display("sliding_window_maximum_tb: done, errors");
        $finish;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq <= hold_req_seq;
            hold_left     <= HOLD_CYCLES;
            i_out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // offer one item, with a random gap first, and wait until it is taken
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic rs);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_restart  <= rs;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // write the window length once the block has gone quiet
    task automatic set_window_len(input int len);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LEN_W'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin
        int                            p;
        int                            k;
        int                            n;
        int                            kind;
        int                            wl;
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SAMPLE_BITS-1:0] ramp;
        logic signed [SAMPLE_BITS-1:0] step;
        logic                          rs;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window of one after reset, extremes and a restart
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b0);

        // zero length acts as one
        set_window_len(0);
        send_sample(16'sh5555, 1'b0);
        send_sample(-16'sd21846, 1'b0);

        // length three: ties, restart with sample, stream shorter than window
        set_window_len(3);
        send_sample(-16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd5, 1'b1);
        send_sample(16'sd7, 1'b0);

        // lengthen mid-stream: results pause until the window refills
        set_window_len(5);
        send_sample(16'sd50, 1'b0);
        send_sample(16'sd40, 1'b0);
        send_sample(16'sd30, 1'b0);

        // above the maximum saturates
        set_window_len(127);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);

        // shorten mid-stream: old front entries expire at once
        set_window_len(2);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd9, 1'b0);

        // random phases, each with its own window length and sample pattern
        items_sent  = 0;
        tx_idle_pct = 26;
        rx_idle_pct <= 83;
        p = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wl = (p % 4 == 3) ? $urandom_range(0, 127) : win_choices[p % 14];
            set_window_len(wl);
            kind = $urandom_range(0, 4);
            n    = (kind == 2 || kind == 3) ? 130 : $urandom_range(40, 140);
            step = $signed(16'($urandom_range(1, 400)));
            ramp = (kind == 2) ? 16'sh7FFF - $signed(16'($urandom_range(0, 255)))
                               : -16'sh8000 + $signed(16'($urandom_range(0, 255)));
            if (p == 2) hold_req_seq <= hold_req_seq + 1;
            for (k = 0; k < n; k++) begin
                // switch idle profile by progress through the random part
                if (items_sent == RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 83;
                    rx_idle_pct <= 26;
                end else if (items_sent == 2 * RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
                if (p % 5 == 3 && k == n / 2) drain_results();
                case (kind)
                    0: s = $signed(16'($urandom));
                    1: s = $signed(16'($urandom_range(0, 8))) - 16'sd4;
                    2: begin
                        s    = ramp;
                        ramp = ramp - step;
                    end
                    3: begin
                        s    = ramp;
                        ramp = ramp + step;
                    end
                    default: s = ($urandom_range(0, 3) == 0)
                                 ? $signed(16'($urandom))
                                 : ramp - $signed(16'($urandom_range(0, 31)));
                endcase
                rs = (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 79) == 0);
                send_sample(s, rs);
            end
            p++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("sliding_window_maximum_tb: done, clean");
        end else begin
            $display("sliding_window_maximum_tb: done, errors");
        end
        $finish;
    end

endmodule
